// File: rtl/core/gmcp_pkg.sv
// Package for the grid minimum-cost-path block.
// Holds the shared field widths, register indexes and the stage control struct.
// No dependencies.
package gmcp_pkg;

  localparam int SUM_W      = 28;
  localparam int OUT_W      = 27;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    ROW_COUNT_IDX = 1'b0,
    COL_COUNT_IDX = 1'b1
  } cfg_reg_e;

  // Control for the cell that sits in the compute stage.
  typedef struct packed {
    logic valid;
    logic row0;
    logic col0;
    logic last;
    logic fwd;
  } stage_ctrl_t;

endpackage

// File: rtl/core/grid_min_cost_path_top.sv
// The last cell is registered in the compute stage, its sum in the result register.
// Throughput: one cell per cycle; the line memory is read once and written once
// per cell, and a sum written in the cycle its entry is read is forwarded.
// The input stalls only while a finished result waits and the next grid ends.
// Reset clears indexes, sizes (both to one) and valid flags; the line memory
// is not cleared, since each entry is written before it is read in a grid.
module grid_min_cost_path_top import gmcp_pkg::*; #(
  parameter int MAX_ROWS  = 1024,
  parameter int MAX_COLS  = 1024,
  parameter int COST_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  cfg_reg_e              cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  cell_valid_i,
  output logic                  cell_ready_o,
  input  logic [COST_BITS-1:0]  cell_cost_i,
  output logic                  min_cost_valid_o,
  input  logic                  min_cost_ready_i,
  output logic [OUT_W-1:0]      min_cost_o
);

  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  stage_ctrl_t          stage;
  logic [COST_BITS-1:0] stage_cost;
  logic [COL_W-1:0]     stage_col, ram_raddr, ram_waddr;
  logic [SUM_W-1:0]     ram_rdata, ram_wdata;
  logic                 ram_re, ram_we, stall;

  gmcp_seq #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .COST_BITS (COST_BITS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cell_valid_i (cell_valid_i),
    .cell_ready_o (cell_ready_o),
    .cell_cost_i  (cell_cost_i),
    .stall_i      (stall),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .stage_o      (stage),
    .stage_cost_o (stage_cost),
    .stage_col_o  (stage_col)
  );

  gmcp_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  gmcp_dp #(
    .MAX_COLS  (MAX_COLS),
    .COST_BITS (COST_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .stage_i          (stage),
    .stage_cost_i     (stage_cost),
    .stage_col_i      (stage_col),
    .ram_rdata_i      (ram_rdata),
    .ram_we_o         (ram_we),
    .ram_waddr_o      (ram_waddr),
    .ram_wdata_o      (ram_wdata),
    .stall_o          (stall),
    .min_cost_valid_o (min_cost_valid_o),
    .min_cost_ready_i (min_cost_ready_i),
    .min_cost_o       (min_cost_o)
  );

endmodule

// File: rtl/core/gmcp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the line of partial path sums; no dependencies.
module gmcp_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/gmcp_seq.sv
// Cell sequencer: size registers, row and column indexes, line read issue.
// Registers each accepted cell into the compute stage. Depends on gmcp_pkg.
module gmcp_seq import gmcp_pkg::*; #(
  parameter int MAX_ROWS  = 1024,
  parameter int MAX_COLS  = 1024,
  parameter int COST_BITS = 16,
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  cfg_reg_e              cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  cell_valid_i,
  output logic                  cell_ready_o,
  input  logic [COST_BITS-1:0]  cell_cost_i,
  input  logic                  stall_i,
  output logic                  ram_re_o,
  output logic [COL_W-1:0]      ram_raddr_o,
  output stage_ctrl_t           stage_o,
  output logic [COST_BITS-1:0]  stage_cost_o,
  output logic [COL_W-1:0]      stage_col_o
);

  localparam int RCNT_W = ($clog2(MAX_ROWS + 1) > CFG_DATA_W) ?
                          $clog2(MAX_ROWS + 1) : CFG_DATA_W;
  localparam int CCNT_W = ($clog2(MAX_COLS + 1) > CFG_DATA_W) ?
                          $clog2(MAX_COLS + 1) : CFG_DATA_W;

  logic [CFG_DATA_W-1:0] row_count_q, row_count_d;
  logic [CFG_DATA_W-1:0] col_count_q, col_count_d;
  logic [ROW_W-1:0]      row_idx_q, row_idx_d;
  logic [COL_W-1:0]      col_idx_q, col_idx_d;
  logic [RCNT_W-1:0]     rows_eff, row_count_ext;
  logic [CCNT_W-1:0]     cols_eff, col_count_ext;
  logic                  cfg_fire, accept, last_row, last_col;
  stage_ctrl_t           stage_q, stage_d;
  logic [COST_BITS-1:0]  cost_q;
  logic [COL_W-1:0]      col_q;

  assign cfg_ready_o  = 1'b1;
  assign cfg_fire     = cfg_valid_i && cfg_ready_o;
  assign cell_ready_o = !stall_i;
  assign accept       = cell_valid_i && cell_ready_o;

  // A size of zero acts as one, and a size above the line limit is clamped.
  always_comb begin
    row_count_ext = RCNT_W'(row_count_q);
    col_count_ext = CCNT_W'(col_count_q);
    if (row_count_ext == '0) begin
      rows_eff = RCNT_W'(1);
    end else if (row_count_ext > RCNT_W'(MAX_ROWS)) begin
      rows_eff = RCNT_W'(MAX_ROWS);
    end else begin
      rows_eff = row_count_ext;
    end
    if (col_count_ext == '0) begin
      cols_eff = CCNT_W'(1);
    end else if (col_count_ext > CCNT_W'(MAX_COLS)) begin
      cols_eff = CCNT_W'(MAX_COLS);
    end else begin
      cols_eff = col_count_ext;
    end
  end

  assign last_row = (RCNT_W'(row_idx_q) == rows_eff - RCNT_W'(1));
  assign last_col = (CCNT_W'(col_idx_q) == cols_eff - CCNT_W'(1));

  always_comb begin
    row_count_d = row_count_q;
    col_count_d = col_count_q;
    row_idx_d   = row_idx_q;
    col_idx_d   = col_idx_q;
    if (cfg_fire) begin
      unique case (cfg_index_i)
        ROW_COUNT_IDX: row_count_d = cfg_data_i;
        COL_COUNT_IDX: col_count_d = cfg_data_i;
        default:       row_count_d = row_count_q;
      endcase
      row_idx_d = '0;
      col_idx_d = '0;
    end else if (accept) begin
      if (last_col) begin
        col_idx_d = '0;
        row_idx_d = last_row ? '0 : row_idx_q + ROW_W'(1);
      end else begin
        col_idx_d = col_idx_q + COL_W'(1);
      end
    end
  end

  // The previous cell writes its column in the cycle this read is issued, so
  // a matching column takes the sum from the compute stage instead.
  always_comb begin
    stage_d = stage_q;
    if (accept) begin
      stage_d.valid = 1'b1;
      stage_d.row0  = (row_idx_q == '0);
      stage_d.col0  = (col_idx_q == '0);
      stage_d.last  = last_row && last_col;
      stage_d.fwd   = stage_q.valid && (col_q == col_idx_q);
    end else if (!stall_i) begin
      stage_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= CFG_DATA_W'(1);
      col_count_q <= CFG_DATA_W'(1);
      row_idx_q   <= '0;
      col_idx_q   <= '0;
      stage_q     <= '0;
    end else begin
      row_count_q <= row_count_d;
      col_count_q <= col_count_d;
      row_idx_q   <= row_idx_d;
      col_idx_q   <= col_idx_d;
      stage_q     <= stage_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cost_q <= cell_cost_i;
      col_q  <= col_idx_q;
    end
  end

  assign ram_re_o     = accept;
  assign ram_raddr_o  = col_idx_q;
  assign stage_o      = stage_q;
  assign stage_cost_o = cost_q;
  assign stage_col_o  = col_q;

`ifndef ASSERT_OFF
  a_col_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CCNT_W'(col_idx_q) < cols_eff)
    else $error("Column index outside the configured line.");

  a_rearm_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_row && last_col |=> row_idx_q == '0 && col_idx_q == '0)
    else $error("Indexes did not rearm after the last cell.");

  a_stall_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_i |-> stage_q.valid && stage_q.last)
    else $error("Compute stage stalled on a cell that is not the last.");
`endif

endmodule

// File: rtl/core/gmcp_dp.sv
// Compute stage: minimum of up, left and diagonal sums plus the cell cost.
// Writes the line memory and holds the result register. Depends on gmcp_pkg.
module gmcp_dp import gmcp_pkg::*; #(
  parameter int MAX_COLS  = 1024,
  parameter int COST_BITS = 16,
  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  stage_ctrl_t          stage_i,
  input  logic [COST_BITS-1:0] stage_cost_i,
  input  logic [COL_W-1:0]     stage_col_i,
  input  logic [SUM_W-1:0]     ram_rdata_i,
  output logic                 ram_we_o,
  output logic [COL_W-1:0]     ram_waddr_o,
  output logic [SUM_W-1:0]     ram_wdata_o,
  output logic                 stall_o,
  output logic                 min_cost_valid_o,
  input  logic                 min_cost_ready_i,
  output logic [OUT_W-1:0]     min_cost_o
);

  logic [SUM_W-1:0] left_q, diag_q, up, best, sum;
  logic [OUT_W-1:0] min_cost_q;
  logic             out_valid_q, out_valid_d, fire;

  assign stall_o = stage_i.valid && stage_i.last && out_valid_q && !min_cost_ready_i;
  assign fire    = stage_i.valid && !stall_o;

  always_comb begin
    if (stage_i.row0) begin
      up = '0;
    end else if (stage_i.fwd) begin
      up = left_q;
    end else begin
      up = ram_rdata_i;
    end
    if (stage_i.row0 && stage_i.col0) begin
      best = '0;
    end else if (stage_i.row0) begin
      best = left_q;
    end else if (stage_i.col0) begin
      best = up;
    end else begin
      best = up;
      if (left_q < best) begin
        best = left_q;
      end
      if (diag_q < best) begin
        best = diag_q;
      end
    end
    sum = SUM_W'(stage_cost_i) + best;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire && stage_i.last) begin
      out_valid_d = 1'b1;
    end else if (min_cost_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      left_q      <= '0;
      diag_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        left_q <= sum;
        diag_q <= up;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && stage_i.last) begin
      min_cost_q <= sum[OUT_W-1:0];
    end
  end

  assign ram_we_o         = fire;
  assign ram_waddr_o      = stage_col_i;
  assign ram_wdata_o      = sum;
  assign min_cost_valid_o = out_valid_q;
  assign min_cost_o       = min_cost_q;

`ifndef ASSERT_OFF
  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(fire && stage_i.last))
    else $error("Result appeared without a finished last cell.");
`endif

endmodule

// File: dv/min_cost_path_checker.sv
`timescale 1ns / 100ps
// Checker for grid_min_cost_path_top: follows register writes and cell transfers,
// predicts the minimum path total of each grid and compares it with the result channel.
// Depends on gmcp_pkg.
module min_cost_path_checker import gmcp_pkg::*; #(
  parameter int MAX_ROWS  = 1024,
  parameter int MAX_COLS  = 1024,
  parameter int COST_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  cfg_reg_e              cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  cell_valid_i,
  input  logic                  cell_ready_i,
  input  logic [COST_BITS-1:0]  cell_cost_i,
  input  logic                  min_cost_valid_i,
  input  logic                  min_cost_ready_i,
  input  logic [OUT_W-1:0]      min_cost_i,
  output int unsigned           mismatch_count_o,
  output int unsigned           pending_o,
  output int unsigned           checked_o
);

  logic [SUM_W-1:0]      line_sums [MAX_COLS];
  logic [SUM_W-1:0]      left_sum_q;
  logic [SUM_W-1:0]      diag_sum_q;
  int unsigned           row_pos;
  int unsigned           col_pos;
  logic [CFG_DATA_W-1:0] rows_reg;
  logic [CFG_DATA_W-1:0] cols_reg;
  logic [OUT_W-1:0]      grid_totals [$];

  function automatic int unsigned clamp_size(logic [CFG_DATA_W-1:0] val, int unsigned limit);
    if (val == 0) return 1;
    if (val > limit) return limit;
    return val;
  endfunction

  function automatic void restart_grid();
    row_pos    = 0;
    col_pos    = 0;
    left_sum_q = '0;
    diag_sum_q = '0;
  endfunction

  function automatic void report_mismatch(string what);
    mismatch_count_o++;
    if (mismatch_count_o <= 10) $display("[%0t] mismatch: %s", $time, what);
  endfunction

  // Advances the running path sums by one cell and queues the total when the grid ends.
  function automatic void add_cell(logic [COST_BITS-1:0] cost);
    int unsigned      rows;
    int unsigned      cols;
    logic [SUM_W-1:0] up_sum;
    logic [SUM_W-1:0] best;
    logic [SUM_W-1:0] cell_sum;
    rows = clamp_size(rows_reg, MAX_ROWS);
    cols = clamp_size(cols_reg, MAX_COLS);
    if (col_pos >= cols) col_pos = 0;
    if (row_pos >= rows) row_pos = 0;
    up_sum = (row_pos != 0) ? line_sums[col_pos] : '0;
    if (row_pos == 0 && col_pos == 0) begin
      best = '0;
    end else if (row_pos == 0) begin
      best = left_sum_q;
    end else if (col_pos == 0) begin
      best = up_sum;
    end else begin
      best = up_sum;
      if (left_sum_q < best) best = left_sum_q;
      if (diag_sum_q < best) best = diag_sum_q;
    end
    cell_sum           = best + cost;
    diag_sum_q         = up_sum;
    left_sum_q         = cell_sum;
    line_sums[col_pos] = cell_sum;
    if (row_pos + 1 == rows && col_pos + 1 == cols) begin
      grid_totals.push_back(cell_sum[OUT_W-1:0]);
      restart_grid();
    end else begin
      col_pos++;
      if (col_pos == cols) begin
        col_pos = 0;
        row_pos++;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [OUT_W-1:0] want;
    if (!rst_ni) begin
      rows_reg = CFG_DATA_W'(1);
      cols_reg = CFG_DATA_W'(1);
      restart_grid();
      grid_totals.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          ROW_COUNT_IDX: rows_reg = cfg_data_i;
          COL_COUNT_IDX: cols_reg = cfg_data_i;
          default: ;
        endcase
        restart_grid();
      end
      if (cell_valid_i && cell_ready_i) add_cell(cell_cost_i);
      if (min_cost_valid_i && min_cost_ready_i) begin
        if (grid_totals.size() == 0) begin
          report_mismatch($sformatf("min_cost %0d arrived with no grid total pending",
                                    min_cost_i));
        end else begin
          want = grid_totals.pop_front();
          checked_o++;
          if (min_cost_i !== want) begin
            report_mismatch($sformatf("min_cost expected %0d, got %0d", want, min_cost_i));
          end
        end
      end
      pending_o <= grid_totals.size();
    end
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for grid_min_cost_path_top: clock, reset, cell and register stimulus,
// result back-pressure and the final verdict. Depends on gmcp_pkg,
// grid_min_cost_path_top and min_cost_path_checker.
module tb_top;
  import gmcp_pkg::*;

  localparam int MAX_ROWS    = 1024;
  localparam int MAX_COLS    = 1024;
  localparam int COST_BITS   = 16;
  localparam int DRAIN_PAD   = 8;
  localparam int DRAIN_LIMIT = 100000;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_CELLS = 50;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_valid      = 1'b0;
  logic                  cfg_ready;
  cfg_reg_e              cfg_index      = ROW_COUNT_IDX;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;
  logic                  cell_valid     = 1'b0;
  logic                  cell_ready;
  logic [COST_BITS-1:0]  cell_cost      = '0;
  logic                  min_cost_valid;
  logic                  min_cost_ready = 1'b0;
  logic [OUT_W-1:0]      min_cost;

  logic                  hold_req       = 1'b0;
  logic                  hold_done      = 1'b0;
  int unsigned           tx_idle_pct    = 0;
  int unsigned           rx_idle_pct    = 0;
  int unsigned           cells_sent     = 0;
  int unsigned           reg_writes     = 0;
  int unsigned           cur_rows       = 1;
  int unsigned           cur_cols       = 1;
  int unsigned           mismatches;
  int unsigned           pending;
  int unsigned           checked;

  logic [COST_BITS-1:0] corner_costs [9] = '{
    16'd1, 16'hFFFF, 16'd3, 16'd2, 16'd0, 16'hFFFF, 16'hFFFF, 16'd7, 16'd4
  };

  grid_min_cost_path_top #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .COST_BITS (COST_BITS)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .cell_valid_i     (cell_valid),
    .cell_ready_o     (cell_ready),
    .cell_cost_i      (cell_cost),
    .min_cost_valid_o (min_cost_valid),
    .min_cost_ready_i (min_cost_ready),
    .min_cost_o       (min_cost)
  );

  min_cost_path_checker #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .COST_BITS (COST_BITS)
  ) path_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .cell_valid_i     (cell_valid),
    .cell_ready_i     (cell_ready),
    .cell_cost_i      (cell_cost),
    .min_cost_valid_i (min_cost_valid),
    .min_cost_ready_i (min_cost_ready),
    .min_cost_i       (min_cost),
    .mismatch_count_o (mismatches),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        min_cost_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done      <= 1'b1;
        min_cost_ready <= 1'b1;
      end else begin
        min_cost_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  function automatic logic [COST_BITS-1:0] pick_cost();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return COST_BITS'($urandom_range(0, 15));
      default: return COST_BITS'($urandom());
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_DATA_W'(1);
      default: return CFG_DATA_W'($urandom_range(2, 10));
    endcase
  endfunction

  // Leaves valid high after the transfer so back-to-back cells need no extra edge.
  task automatic send_cell(input logic [COST_BITS-1:0] cost);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      cell_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    cell_valid <= 1'b1;
    cell_cost  <= cost;
    do @(posedge clk_i); while (!cell_ready);
    cells_sent++;
  endtask

  task automatic send_grid(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_cell(pick_cost());
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
    if (idx == ROW_COUNT_IDX) cur_rows = val;
    else cur_cols = val;
    reg_writes++;
  endtask

  // Waits until every queued grid total has been returned, then lets the pipeline settle.
  task automatic drain();
    int unsigned waited;
    waited = 0;
    cell_valid <= 1'b0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (pending != 0 && waited < DRAIN_LIMIT);
    repeat (DRAIN_PAD) @(posedge clk_i);
  endtask

  task automatic run_random_grids(input int unsigned budget);
    int unsigned sent;
    int unsigned ncells;
    bit          do_rows;
    bit          do_cols;
    sent = 0;
    while (sent < budget) begin
      drain();
      do_rows = ($urandom_range(0, 3) != 0);
      do_cols = !do_rows || ($urandom_range(0, 3) != 0);
      if (do_rows) write_reg(ROW_COUNT_IDX, pick_size());
      if (do_cols) write_reg(COL_COUNT_IDX, pick_size());
      ncells = (cur_rows == 0 ? 1 : cur_rows) * (cur_cols == 0 ? 1 : cur_cols);
      repeat ($urandom_range(1, 4)) begin
        send_grid(ncells);
        sent += ncells;
      end
      // Now and then a grid is cut short; the next register write drops it.
      if ($urandom_range(0, 7) == 0) begin
        send_grid($urandom_range(0, ncells - 1));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sizes after reset are one by one, so every cell is a grid of its own.
    send_cell('0);
    send_cell('1);
    drain();
    write_reg(ROW_COUNT_IDX, '0);
    write_reg(COL_COUNT_IDX, '0);
    send_cell(16'h5555);
    send_cell(16'hAAAA);
    drain();
    write_reg(ROW_COUNT_IDX, CFG_DATA_W'(3));
    write_reg(COL_COUNT_IDX, CFG_DATA_W'(3));
    foreach (corner_costs[i]) send_cell(corner_costs[i]);
    drain();
    write_reg(ROW_COUNT_IDX, CFG_DATA_W'(2));
    write_reg(COL_COUNT_IDX, CFG_DATA_W'(4));
    send_grid(3);
    drain();
    write_reg(COL_COUNT_IDX, CFG_DATA_W'(4));
    send_grid(8);

    tx_idle_pct = 37;
    rx_idle_pct = 79;
    run_random_grids(PHASE_CELLS);
    tx_idle_pct = 79;
    rx_idle_pct = 37;
    run_random_grids(PHASE_CELLS);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random_grids(PHASE_CELLS);

    // An oversize column count clamps to the full line.
    drain();
    write_reg(ROW_COUNT_IDX, CFG_DATA_W'(1));
    write_reg(COL_COUNT_IDX, '1);
    send_grid(MAX_COLS);

    // Single-cell grids against a long result stall fill the block and block its input.
    drain();
    write_reg(ROW_COUNT_IDX, CFG_DATA_W'(1));
    write_reg(COL_COUNT_IDX, CFG_DATA_W'(1));
    hold_req <= 1'b1;
    send_grid(24);
    drain();
    hold_req <= 1'b0;
    drain();

    $display("Run covered %0d cells and %0d register writes; %0d grid totals checked.",
             cells_sent, reg_writes, checked);
    $display("Included zero and oversize dimensions, dropped grids and a %0d-cycle stall.",
             HOLD_CYCLES);
    if (pending != 0) $display("%0d grid totals never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
